FILE: src/chb_pkg.sv
// Shared types and constants for the command history buffer.
// Used by chb_ctrl, chb_datapath and command_history_buffer; depends on nothing.
`default_nettype none

package chb_pkg;

   // Default sizes
   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int LINE_BYTES_DEF    = 64;

   // Field widths
   localparam int CHAR_W   = 8;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OLDER = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NEWER = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_ENTRY = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PAST  = 2'd2;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_CMP,
      ST_CLOSE,
      ST_COPY,
      ST_STREAM
   } chb_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;     // item taken this cycle
      logic take_char;  // append the item's character
      logic add_cmp;    // finish duplicate compare
      logic close;      // close the pending line
      logic copy;       // copy pending line into the store
      logic recall;     // serve a recall item
      logic stream;     // stream the selected entry
   } chb_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic s1_empty;        // result stage free
      logic req_is_add;
      logic req_is_recall;
      logic req_char_nz;
      logic req_eol;
      logic recall_streams;  // recall selects an entry to stream
      logic item_eol;        // latched end mark of the taken item
      logic close_stores;    // close writes a new entry
      logic copy_done;
      logic stream_done;     // last character issued this cycle
   } chb_stat_type;

endpackage

`default_nettype wire

FILE: src/chb_ctrl.sv
// Controller state machine of the command history buffer.
// Depends on chb_pkg; drives chb_datapath through command and status structs.
`default_nettype none

module chb_ctrl
   import chb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output chb_cmd_type       cmd,
   input  wire chb_stat_type st
);

   chb_state_type state_ff, state_in;
   logic          accept;

   // Take an item only in idle with the result stage free
   assign req_tready = (state_ff == ST_IDLE) && st.s1_empty;
   assign accept     = req_tvalid && req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (st.req_is_add) begin
                  if (st.req_char_nz) begin
                     state_in = ST_ADD_CMP;
                  end else if (st.req_eol) begin
                     state_in = ST_CLOSE;
                  end
               end else if (st.req_is_recall && st.recall_streams) begin
                  state_in = ST_STREAM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ADD_CMP: begin
            state_in = st.item_eol ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE: begin
            state_in = st.close_stores ? ST_COPY : ST_IDLE;
         end
         ST_COPY: begin
            if (st.copy_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_STREAM: begin
            if (st.stream_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs
   always_comb begin
      cmd           = '0;
      cmd.accept    = accept;
      cmd.take_char = accept && st.req_is_add && st.req_char_nz;
      cmd.recall    = accept && st.req_is_recall;
      unique case (state_ff)
         ST_IDLE:    cmd.accept  = accept;
         ST_ADD_CMP: cmd.add_cmp = 1'b1;
         ST_CLOSE:   cmd.close   = 1'b1;
         ST_COPY:    cmd.copy    = 1'b1;
         ST_STREAM:  cmd.stream  = 1'b1;
         default:    cmd.accept  = accept;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/chb_datapath.sv
// Datapath of the command history buffer: line store, pending line, ring pointers,
// recall cursor and the result pipeline. Depends on chb_pkg; commanded by chb_ctrl.
`default_nettype none

module chb_datapath
   import chb_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int LINE_BYTES    = LINE_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [CHAR_W-1:0]   req_tdata,
   input  wire logic                req_tlast,
   input  wire logic [MODE_W-1:0]   req_tuser,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [CHAR_W-1:0]        rsp_tdata,
   output logic                     rsp_tlast,
   output logic [STATUS_W-1:0]      rsp_tuser,
   input  wire chb_cmd_type         cmd,
   output chb_stat_type             st
);

   localparam int SW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CW   = $clog2(HISTORY_DEPTH + 1);
   localparam int LIW  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam int LLW  = $clog2(LINE_BYTES + 1);
   localparam logic [CW-1:0]  DEPTH_C = CW'(HISTORY_DEPTH);
   localparam logic [LLW-1:0] KEEP_C  = LLW'(LINE_BYTES - 1);
   localparam logic [LLW-1:0] SAT_C   = LLW'(LINE_BYTES);

   // Memories
   logic [CHAR_W-1:0] line_mem [HISTORY_DEPTH][LINE_BYTES];
   logic [LLW-1:0]    len_mem  [HISTORY_DEPTH];
   logic [CHAR_W-1:0] inc_mem  [LINE_BYTES];

   // Ring and line state
   logic [SW-1:0]  oldest_slot_ff, oldest_slot_in;
   logic [CW-1:0]  entry_count_ff, entry_count_in;
   logic [CW-1:0]  recall_cursor_ff, recall_cursor_in;
   logic [LLW-1:0] inc_len_ff, inc_len_in;
   logic           matches_ff, matches_in;
   logic [SW-1:0]  newest_slot_ff;
   logic [LLW-1:0] newest_len_ff;

   // Compare, copy and stream registers
   logic              cmp_pending_ff;
   logic [CHAR_W-1:0] cmp_char_ff;
   logic [LLW-1:0]    cmp_pos_ff;
   logic              item_eol_ff;
   logic [SW-1:0]     store_slot_ff;
   logic [LLW-1:0]    copy_len_ff;
   logic [LLW-1:0]    cp_rd_i_ff;
   logic              cp_wr_valid_ff;
   logic [LIW-1:0]    cp_wr_idx_ff;
   logic [CHAR_W-1:0] inc_rd_ff;
   logic [SW-1:0]     str_slot_ff;
   logic [LLW-1:0]    str_i_ff;
   logic [LLW-1:0]    len_rd_ff;
   logic [CHAR_W-1:0] line_rd_ff;

   // Result stage and output register
   logic                s1_valid_ff, s1_last_ff, s1_zero_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic                out_valid_ff, out_last_ff;
   logic [CHAR_W-1:0]   out_char_ff;
   logic [STATUS_W-1:0] out_status_ff;

   // Combinational helpers
   logic           p_keep, take_rd, dup, nonempty, stores, not_full;
   logic [LLW-1:0] clen;
   logic [SW-1:0]  store_slot, next_oldest, rc_slot;
   logic [CW-1:0]  c_min, c_older, c_next, rc_cursor;
   logic           newer_ok, rc_empty, rc_past, rc_stream, is_older, is_recall;
   logic [LLW-1:0] eff_len;
   logic           s1_adv, s1_free, stream_issue, stream_last;
   logic           push_status, s1_load, s1_load_last, s1_load_zero;
   logic [STATUS_W-1:0] s1_load_status;
   logic           line_rd_en;
   logic [SW-1:0]  line_rd_slot;
   logic [LIW-1:0] line_rd_idx;
   logic           cp_issue;

   // Slot k places after the oldest entry, wrapped once
   function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                             input logic [CW-1:0] k);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(k);
      if (sum >= (CW + 1)'(HISTORY_DEPTH)) begin
         sum = sum - (CW + 1)'(HISTORY_DEPTH);
      end
      return sum[SW-1:0];
   endfunction

   // Decode the offered item
   assign is_recall = (req_tuser == MODE_OLDER) || (req_tuser == MODE_NEWER);
   assign is_older  = (req_tuser == MODE_OLDER);

   // Append path
   assign p_keep  = inc_len_ff < KEEP_C;
   assign take_rd = cmd.take_char && p_keep;

   // Close path
   assign nonempty    = inc_len_ff != '0;
   assign dup         = (entry_count_ff != '0) && matches_ff && (inc_len_ff == newest_len_ff);
   assign stores      = nonempty && !dup;
   assign clen        = (inc_len_ff > KEEP_C) ? KEEP_C : inc_len_ff;
   assign not_full    = entry_count_ff < DEPTH_C;
   assign store_slot  = not_full ? slot_of(oldest_slot_ff, entry_count_ff) : oldest_slot_ff;
   assign next_oldest = slot_of(oldest_slot_ff, CW'(1));

   // Recall cursor math
   assign c_min     = (recall_cursor_ff > entry_count_ff) ? entry_count_ff : recall_cursor_ff;
   assign c_older   = (c_min != '0) ? c_min - CW'(1) : c_min;
   assign c_next    = recall_cursor_ff + CW'(1);
   assign newer_ok  = ((CW + 1)'(recall_cursor_ff) + (CW + 1)'(1)) < (CW + 1)'(entry_count_ff);
   assign rc_empty  = entry_count_ff == '0;
   assign rc_past   = !rc_empty && !is_older && !newer_ok;
   assign rc_stream = is_recall && !rc_empty && !rc_past;
   assign rc_cursor = is_older ? c_older : c_next;
   assign rc_slot   = slot_of(oldest_slot_ff, rc_cursor);

   // Stream issue
   assign eff_len      = (len_rd_ff == '0) ? LLW'(1) : len_rd_ff;
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign s1_free      = !s1_valid_ff || s1_adv;
   assign stream_issue = cmd.stream && s1_free && (str_i_ff < eff_len);
   assign stream_last  = (LLW'(str_i_ff + LLW'(1)) >= eff_len);

   // Result stage load
   assign push_status    = cmd.recall && is_recall && !rc_stream;
   assign s1_load        = push_status || stream_issue;
   assign s1_load_last   = push_status || stream_last;
   assign s1_load_zero   = push_status || (len_rd_ff == '0);
   assign s1_load_status = !push_status ? STATUS_ENTRY :
                           (rc_empty ? STATUS_EMPTY : STATUS_PAST);

   // Line store read port
   assign line_rd_en   = take_rd || stream_issue;
   assign line_rd_slot = take_rd ? newest_slot_ff : str_slot_ff;
   assign line_rd_idx  = take_rd ? inc_len_ff[LIW-1:0] : str_i_ff[LIW-1:0];

   assign cp_issue = cmd.copy && (cp_rd_i_ff < copy_len_ff);

   // Next values of ring and line state
   always_comb begin
      oldest_slot_in   = oldest_slot_ff;
      entry_count_in   = entry_count_ff;
      recall_cursor_in = recall_cursor_ff;
      inc_len_in       = inc_len_ff;
      matches_in       = matches_ff;
      if (cmd.take_char) begin
         if (!p_keep) begin
            matches_in = 1'b0;
         end
         if (inc_len_ff < SAT_C) begin
            inc_len_in = inc_len_ff + LLW'(1);
         end
      end
      if (cmd.add_cmp && cmp_pending_ff &&
          ((cmp_pos_ff >= newest_len_ff) || (line_rd_ff != cmp_char_ff))) begin
         matches_in = 1'b0;
      end
      if (cmd.close) begin
         inc_len_in = '0;
         matches_in = 1'b1;
         if (nonempty && dup) begin
            recall_cursor_in = entry_count_ff;
         end
         if (stores) begin
            if (not_full) begin
               entry_count_in   = entry_count_ff + CW'(1);
               recall_cursor_in = entry_count_ff + CW'(1);
            end else begin
               oldest_slot_in   = next_oldest;
               recall_cursor_in = entry_count_ff;
            end
         end
      end
      if (cmd.recall && is_recall && !rc_empty) begin
         recall_cursor_in = rc_past ? entry_count_ff : rc_cursor;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_slot_ff   <= '0;
         entry_count_ff   <= '0;
         recall_cursor_ff <= '0;
         inc_len_ff       <= '0;
         matches_ff       <= 1'b1;
         cmp_pending_ff   <= 1'b0;
         cp_wr_valid_ff   <= 1'b0;
         s1_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         oldest_slot_ff   <= oldest_slot_in;
         entry_count_ff   <= entry_count_in;
         recall_cursor_ff <= recall_cursor_in;
         inc_len_ff       <= inc_len_in;
         matches_ff       <= matches_in;
         if (cmd.take_char) begin
            cmp_pending_ff <= p_keep && (entry_count_ff != '0);
         end
         cp_wr_valid_ff <= cp_issue;
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_eol_ff <= req_tlast;
      end
      if (cmd.take_char) begin
         cmp_char_ff <= req_tdata;
         cmp_pos_ff  <= inc_len_ff;
      end
      if (cmd.close && stores) begin
         newest_slot_ff <= store_slot;
         newest_len_ff  <= clen;
         store_slot_ff  <= store_slot;
         copy_len_ff    <= clen;
         cp_rd_i_ff     <= '0;
      end else if (cp_issue) begin
         cp_rd_i_ff <= cp_rd_i_ff + LLW'(1);
      end
      cp_wr_idx_ff <= cp_rd_i_ff[LIW-1:0];
      if (cmd.recall && rc_stream) begin
         str_slot_ff <= rc_slot;
         str_i_ff    <= '0;
      end else if (stream_issue) begin
         str_i_ff <= str_i_ff + LLW'(1);
      end
      if (s1_load) begin
         s1_last_ff   <= s1_load_last;
         s1_zero_ff   <= s1_load_zero;
         s1_status_ff <= s1_load_status;
      end
      if (s1_adv) begin
         out_char_ff   <= s1_zero_ff ? '0 : line_rd_ff;
         out_last_ff   <= s1_last_ff;
         out_status_ff <= s1_status_ff;
      end
   end

   // Pending line memory: append and copy read
   always_ff @(posedge clock) begin
      if (take_rd) begin
         inc_mem[inc_len_ff[LIW-1:0]] <= req_tdata;
      end
      if (cp_issue) begin
         inc_rd_ff <= inc_mem[cp_rd_i_ff[LIW-1:0]];
      end
   end

   // Line store: one read port, one write port
   always_ff @(posedge clock) begin
      if (line_rd_en) begin
         line_rd_ff <= line_mem[line_rd_slot][line_rd_idx];
      end
      if (cp_wr_valid_ff) begin
         line_mem[store_slot_ff][cp_wr_idx_ff] <= inc_rd_ff;
      end
   end

   // Entry lengths
   always_ff @(posedge clock) begin
      if (cmd.close && stores) begin
         len_mem[store_slot] <= clen;
      end
      if (cmd.recall && rc_stream) begin
         len_rd_ff <= len_mem[rc_slot];
      end
   end

   // Status to controller
   always_comb begin
      st                = '0;
      st.s1_empty       = !s1_valid_ff;
      st.req_is_add     = req_tuser == MODE_ADD;
      st.req_is_recall  = is_recall;
      st.req_char_nz    = req_tdata != '0;
      st.req_eol        = req_tlast;
      st.recall_streams = rc_stream;
      st.item_eol       = item_eol_ff;
      st.close_stores   = stores;
      st.copy_done      = (cp_rd_i_ff >= copy_len_ff) && !cp_wr_valid_ff;
      st.stream_done    = stream_issue && stream_last;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

`ifndef SYNTH
   // Cursor never points beyond the entry count
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      recall_cursor_ff <= entry_count_ff)
      else $error("recall cursor beyond entry count");

   // Result stage is never overwritten while it holds an item
   a_s1_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_load |-> (!s1_valid_ff || s1_adv))
      else $error("result stage overrun");

   // Copy writes and streaming never overlap
   a_copy_vs_stream: assert property (@(posedge clock) disable iff (reset)
      cp_wr_valid_ff |-> !stream_issue)
      else $error("copy write during stream");

   // Compare read only with an empty result stage
   a_cmp_read_free: assert property (@(posedge clock) disable iff (reset)
      take_rd |-> !s1_valid_ff)
      else $error("compare read while result stage busy");
`endif

endmodule

`default_nettype wire

FILE: src/command_history_buffer.sv
// Top level of the command history buffer: controller plus datapath.
// Depends on chb_pkg, chb_ctrl and chb_datapath.
//
//   channel  | ports                         | payload
//   ---------+-------------------------------+----------------------------------------
//   request  | req_tvalid/tready/tdata/tlast | tdata: character; tuser: mode;
//            | req_tuser                     | tlast: end of line
//   response | rsp_tvalid/tready/tdata/tlast | tdata: text_char; tuser: status;
//            | rsp_tuser                     | tlast: last_char
//
// An add item with a character also passes through ST_ADD_CMP (line store read for the duplicate check).
// A closing end mark adds ST_CLOSE, plus ST_COPY over the copy length when the line is stored;
// the copy moves the pending line one character per cycle through its memory port.
// A recall is served in idle, then streams a selected entry one character per cycle from the
// line store port unless the response stalls; the next item waits until the result stage drains.
// Reset is synchronous and needs no clearing pass; a stalled response holds the stream.
`default_nettype none

module command_history_buffer
   import chb_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int LINE_BYTES    = LINE_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [CHAR_W-1:0]   req_tdata,   // [7:0] character
   input  wire logic                req_tlast,
   input  wire logic [MODE_W-1:0]   req_tuser,   // [1:0] mode
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [CHAR_W-1:0]        rsp_tdata,   // [7:0] text_char
   output logic                     rsp_tlast,
   output logic [STATUS_W-1:0]      rsp_tuser    // [1:0] status
);

   chb_cmd_type  cmd;
   chb_stat_type st;

   // Sequencer
   chb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .st         (st)
   );

   // Storage and result pipeline
   chb_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .LINE_BYTES    (LINE_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .st         (st)
   );

endmodule

`default_nettype wire
